FILE: rtl/core/swept_sphere_point_marker_macros.svh
`ifndef SWEPT_SPHERE_POINT_MARKER_MACROS_SVH
`define SWEPT_SPHERE_POINT_MARKER_MACROS_SVH

// property must hold at every clock edge out of reset
`define SSPM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sspm check failed");

// expression must never be true
`define SSPM_ASSERT_NEVER(label, expr) \
  `SSPM_ASSERT(label, !(expr))

`endif

FILE: rtl/core/sspm_pkg.sv
package sspm_pkg;

  localparam int RADIUS_WIDTH = 20;
  localparam int MARK_WIDTH   = 8;
  localparam int R2_WIDTH     = 2 * RADIUS_WIDTH;

  localparam logic [MARK_WIDTH-1:0] MARK_NONE    = 8'd0;
  localparam logic [MARK_WIDTH-1:0] MARK_CLEARED = 8'd1;

  typedef enum logic [2:0] {
    REG_CUR_X     = 3'd0,
    REG_CUR_Y     = 3'd1,
    REG_CUR_Z     = 3'd2,
    REG_LAST_X    = 3'd3,
    REG_LAST_Y    = 3'd4,
    REG_LAST_Z    = 3'd5,
    REG_RADIUS    = 3'd6,
    REG_HIGHLIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                  valid;
    logic [MARK_WIDTH-1:0] old_mark;
    logic                  clear;
  } ctrl_t;

endpackage

FILE: rtl/core/sspm_front.sv
module sspm_front import sspm_pkg::*; #(
  parameter int W = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  ctrl_t                       ctrl_i,
  input  logic signed [W-1:0]         p_i [3],
  input  logic signed [W-1:0]         c_i [3],
  input  logic signed [W-1:0]         l_i [3],
  input  logic [RADIUS_WIDTH-1:0]     r_i,
  output ctrl_t                       ctrl_o,
  output logic signed [2*W+1:0]       qsq_o [3],
  output logic signed [2*W+1:0]       dsq_o [3],
  output logic signed [2*W+1:0]       qd_o [3],
  output logic [R2_WIDTH-1:0]         r2_o,
  output logic                        inbox_o,
  output logic                        same_o
);

  localparam int QW = W + 1;
  localparam int EW = ((W > RADIUS_WIDTH) ? W : RADIUS_WIDTH) + 3;

  logic signed [QW-1:0] q_d [3], q_q [3], d_d [3], d_q [3];
  logic inbox_d, inbox_a_q, same_d, same_a_q;
  logic [RADIUS_WIDTH-1:0] r_a_q;
  ctrl_t ctrl_a_q, ctrl_b_q;
  logic signed [2*W+1:0] qsq_q [3], dsq_q [3], qd_q [3];
  logic [R2_WIDTH-1:0] r2_q;
  logic inbox_b_q, same_b_q;

  always_comb begin
    logic signed [EW-1:0] pe, ce, le, mn, mx, re;
    inbox_d = 1'b1;
    same_d  = 1'b1;
    re = $signed({{(EW-RADIUS_WIDTH){1'b0}}, r_i});
    for (int i = 0; i < 3; i++) begin
      pe = EW'(p_i[i]);
      ce = EW'(c_i[i]);
      le = EW'(l_i[i]);
      mn = (ce < le) ? ce : le;
      mx = (ce > le) ? ce : le;
      if (!(pe > (mn - re) && pe < (mx + re))) inbox_d = 1'b0;
      if (c_i[i] != l_i[i]) same_d = 1'b0;
      q_d[i] = QW'(p_i[i]) - QW'(c_i[i]);
      d_d[i] = QW'(l_i[i]) - QW'(c_i[i]);
    end
  end

  // stage a: differences and box test
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else if (en_i) begin
      ctrl_a_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q       <= q_d;
      d_q       <= d_d;
      inbox_a_q <= inbox_d;
      same_a_q  <= same_d;
      r_a_q     <= r_i;
    end
  end

  // stage b: squares and cross terms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
    end else if (en_i) begin
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        qsq_q[i] <= q_q[i] * q_q[i];
        dsq_q[i] <= d_q[i] * d_q[i];
        qd_q[i]  <= q_q[i] * d_q[i];
      end
      r2_q      <= r_a_q * r_a_q;
      inbox_b_q <= inbox_a_q;
      same_b_q  <= same_a_q;
    end
  end

  assign ctrl_o  = ctrl_b_q;
  assign qsq_o   = qsq_q;
  assign dsq_o   = dsq_q;
  assign qd_o    = qd_q;
  assign r2_o    = r2_q;
  assign inbox_o = inbox_b_q;
  assign same_o  = same_b_q;

endmodule

FILE: rtl/core/sspm_wide_mul.sv
module sspm_wide_mul #(
  parameter int AW = 50
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   a_i,
  input  logic [AW-1:0]   b_i,
  output logic [2*AW-1:0] p_o
);

  localparam int K = (AW + 1) / 2;

  logic [2*K-1:0] a_ext, b_ext;
  logic [2*K-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [4*K-1:0] p_q;

  assign a_ext = (2*K)'(a_i);
  assign b_ext = (2*K)'(b_i);

  // partial products on half words
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_ext[K-1:0]   * b_ext[K-1:0];
      lh_q <= a_ext[K-1:0]   * b_ext[2*K-1:K];
      hl_q <= a_ext[2*K-1:K] * b_ext[K-1:0];
      hh_q <= a_ext[2*K-1:K] * b_ext[2*K-1:K];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ((4*K)'(hh_q) << (2*K)) + (((4*K)'(lh_q) + (4*K)'(hl_q)) << K)
             + (4*K)'(ll_q);
    end
  end

  assign p_o = p_q[2*AW-1:0];

endmodule

FILE: rtl/core/swept_sphere_point_marker.sv
// Point-in-capsule marker: one point per clock while the output is not stalled,
// results in order. A point accepted on in_valid_i/in_ready_o passes through
// the difference/box stage, the square stage, the sum stage and the split
// multipliers for the cylinder test, with the final compare in the output
// register. All stages advance together, so a stalled output holds the whole
// pipeline and in_ready_o follows output space. Configuration writes are taken
// every cycle and must only happen while the pipeline is empty.
module swept_sphere_point_marker import sspm_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [((COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH)-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic [MARK_WIDTH-1:0]         old_mark_i,
  input  logic                          clear_request_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [MARK_WIDTH-1:0]         new_mark_o,
  output logic                          mark_changed_o,
  output logic                          selected_o,
  output logic                          cleared_hit_o
);

  `include "swept_sphere_point_marker_macros.svh"

  localparam int W  = COORD_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int DW = SW + 2;
  localparam int M  = (SW > R2_WIDTH) ? SW : R2_WIDTH;

  logic signed [W-1:0] cur_q [3], last_q [3], pt [3];
  logic [RADIUS_WIDTH-1:0] radius_q;
  logic [MARK_WIDTH-1:0] highlight_q;
  logic en;
  ctrl_t ctrl_in, ctrl_b, ctrl_c_q, ctrl_d_q, ctrl_e_q;

  logic signed [SW-1:0] qsq [3], dsq [3], qd [3];
  logic [R2_WIDTH-1:0] r2;
  logic inbox, same;

  logic [M-1:0] q2_d, len2_d, dotu_d;
  logic signed [DW-1:0] dot_d;
  logic [M-1:0] q2_q, len2_q, r2_q, dotu_q;
  logic hit_c_q, try_c_q, hit_d_q, try_d_q, hit_e_q, try_e_q;
  logic [2*M-1:0] lhs, r2len, dotsq;
  logic [2*M:0] rhs;
  logic hit;

  logic out_valid_q, changed_q, selected_q, cleared_q;
  logic [MARK_WIDTH-1:0] mark_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '{default: '0};
      last_q      <= '{default: '0};
      radius_q    <= '0;
      highlight_q <= 8'd100;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_CUR_X:     cur_q[0]    <= cfg_data_i[W-1:0];
        REG_CUR_Y:     cur_q[1]    <= cfg_data_i[W-1:0];
        REG_CUR_Z:     cur_q[2]    <= cfg_data_i[W-1:0];
        REG_LAST_X:    last_q[0]   <= cfg_data_i[W-1:0];
        REG_LAST_Y:    last_q[1]   <= cfg_data_i[W-1:0];
        REG_LAST_Z:    last_q[2]   <= cfg_data_i[W-1:0];
        REG_RADIUS:    radius_q    <= cfg_data_i[RADIUS_WIDTH-1:0];
        REG_HIGHLIGHT: highlight_q <= cfg_data_i[MARK_WIDTH-1:0];
        default:       ;
      endcase
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign ctrl_in = '{valid: in_valid_i, old_mark: old_mark_i, clear: clear_request_i};

  sspm_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctrl_i  (ctrl_in),
    .p_i     (pt),
    .c_i     (cur_q),
    .l_i     (last_q),
    .r_i     (radius_q),
    .ctrl_o  (ctrl_b),
    .qsq_o   (qsq),
    .dsq_o   (dsq),
    .qd_o    (qd),
    .r2_o    (r2),
    .inbox_o (inbox),
    .same_o  (same)
  );

  // stage c: sums, sphere test and dot range
  always_comb begin
    q2_d   = M'($unsigned(qsq[0])) + M'($unsigned(qsq[1])) + M'($unsigned(qsq[2]));
    len2_d = M'($unsigned(dsq[0])) + M'($unsigned(dsq[1])) + M'($unsigned(dsq[2]));
    dot_d  = DW'(qd[0]) + DW'(qd[1]) + DW'(qd[2]);
    dotu_d = M'(dot_d[SW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_c_q <= '0;
      ctrl_d_q <= '0;
      ctrl_e_q <= '0;
    end else if (en) begin
      ctrl_c_q <= ctrl_b;
      ctrl_d_q <= ctrl_c_q;
      ctrl_e_q <= ctrl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2_q    <= q2_d;
      len2_q  <= len2_d;
      r2_q    <= M'(r2);
      dotu_q  <= dotu_d;
      hit_c_q <= inbox && (q2_d <= M'(r2));
      try_c_q <= inbox && !(q2_d <= M'(r2)) && !same && !dot_d[DW-1] && (dotu_d <= len2_d);
      hit_d_q <= hit_c_q;
      try_d_q <= try_c_q;
      hit_e_q <= hit_d_q;
      try_e_q <= try_d_q;
    end
  end

  // stages d and e: cylinder products
  sspm_wide_mul #(.AW(M)) u_mul_lhs (
    .clk_i (clk_i), .en_i (en), .a_i (q2_q), .b_i (len2_q), .p_o (lhs)
  );

  sspm_wide_mul #(.AW(M)) u_mul_r2len (
    .clk_i (clk_i), .en_i (en), .a_i (r2_q), .b_i (len2_q), .p_o (r2len)
  );

  sspm_wide_mul #(.AW(M)) u_mul_dotsq (
    .clk_i (clk_i), .en_i (en), .a_i (dotu_q), .b_i (dotu_q), .p_o (dotsq)
  );

  // stage f: cylinder compare and mark
  assign rhs = (2*M+1)'(r2len) + (2*M+1)'(dotsq);
  assign hit = hit_e_q || (try_e_q && ((2*M+1)'(lhs) <= rhs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctrl_e_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctrl_e_q.old_mark == MARK_CLEARED) begin
        mark_q     <= MARK_CLEARED;
        changed_q  <= 1'b0;
        selected_q <= 1'b0;
        cleared_q  <= 1'b0;
      end else if (hit) begin
        mark_q     <= ctrl_e_q.clear ? MARK_CLEARED : highlight_q;
        changed_q  <= 1'b1;
        selected_q <= !ctrl_e_q.clear;
        cleared_q  <= ctrl_e_q.clear;
      end else begin
        mark_q     <= MARK_NONE;
        changed_q  <= (ctrl_e_q.old_mark != MARK_NONE);
        selected_q <= 1'b0;
        cleared_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_mark_o     = mark_q;
  assign mark_changed_o = changed_q;
  assign selected_o     = selected_q;
  assign cleared_hit_o  = cleared_q;

  `SSPM_ASSERT_NEVER(a_flags_exclusive, out_valid_o && selected_o && cleared_hit_o)
  `SSPM_ASSERT(a_hit_changes, out_valid_o && (selected_o || cleared_hit_o) |-> mark_changed_o)
  `SSPM_ASSERT(a_cleared_mark, out_valid_o && cleared_hit_o |-> new_mark_o == MARK_CLEARED)

endmodule
